// ===== rtl/srtt_pkg.sv =====
// Shared types and constants for the sorted transition table.
package srtt_pkg;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned HANDLE_BITS = 8;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned OUT_IDX_W   = 6;
  localparam int unsigned OUT_CNT_W   = 7;
  localparam int unsigned S_DATA_W    = 72;
  localparam int unsigned M_DATA_W    = 88;
  localparam int unsigned M_USER_W    = 3;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } srtt_cmd_t;

endpackage

// ===== rtl/srtt_ctrl.sv =====
// Controller for the sorted transition table: sequencing and output handshake.
module srtt_ctrl
  import srtt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  output srtt_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  always_comb begin
    out_free      = !out_valid_q || m_ready_i;
    s_ready_o     = (state_q == ST_IDLE) || ((state_q == ST_UPD) && out_free);
    accept        = s_valid_i && s_ready_o;
    cmd_o.load    = accept;
    cmd_o.compare = (state_q == ST_CMP);
    cmd_o.update  = (state_q == ST_UPD) && out_free;
    state_d       = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) state_d = accept ? ST_CMP : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (cmd_o.update) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

// ===== rtl/srtt_datapath.sv =====
// Datapath for the sorted transition table: entry cells, compare vectors, result register.
module srtt_datapath
  import srtt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  srtt_cmd_t              cmd_i,
  input  logic                   op_i,
  input  logic [TIME_W-1:0]      time_i,
  input  logic [HANDLE_BITS-1:0] handle_i,
  output logic                   found_o,
  output logic [TIME_W-1:0]      entry_time_o,
  output logic [HANDLE_BITS-1:0] entry_handle_o,
  output logic [OUT_IDX_W-1:0]   entry_index_o,
  output logic                   replaced_o,
  output logic                   table_full_o,
  output logic [OUT_CNT_W-1:0]   entry_count_o
);

  logic [TIME_W-1:0]      times_q   [DEPTH];
  logic [HANDLE_BITS-1:0] handles_q [DEPTH];
  logic [CNT_W-1:0]       count_q, count_d;

  op_e                    req_op_q;
  logic [TIME_W-1:0]      req_time_q;
  logic [HANDLE_BITS-1:0] req_handle_q;

  logic [DEPTH-1:0] lt_q, eq_q, le_q;
  logic [DEPTH-1:0] lt_d, eq_d, le_d;

  logic [DEPTH-1:0]       ins_oh, lk_oh, sel_oh;
  logic [IDX_W-1:0]       ins_idx, sel_idx;
  logic [TIME_W-1:0]      sel_time;
  logic [HANDLE_BITS-1:0] sel_handle;
  logic                   hit, full, do_insert, any_le;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      logic vld;
      vld     = CNT_W'(i) < count_q;
      lt_d[i] = vld && ($signed(times_q[i]) < $signed(req_time_q));
      eq_d[i] = vld && (times_q[i] == req_time_q);
      le_d[i] = vld && !($signed(req_time_q) < $signed(times_q[i]));
    end
  end

  always_comb begin
    ins_idx    = '0;
    sel_idx    = '0;
    sel_time   = '0;
    sel_handle = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        ins_oh[i] = !lt_q[i];
      end else begin
        ins_oh[i] = !lt_q[i] && lt_q[i-1];
      end
      if (i == DEPTH - 1) begin
        lk_oh[i] = le_q[i];
      end else begin
        lk_oh[i] = le_q[i] && !le_q[i+1];
      end
    end
    any_le = |le_q;
    sel_oh = any_le ? lk_oh : DEPTH'(1);
    for (int i = 0; i < DEPTH; i++) begin
      if (ins_oh[i]) ins_idx = ins_idx | IDX_W'(i);
      if (sel_oh[i]) begin
        sel_idx    = sel_idx | IDX_W'(i);
        sel_time   = sel_time | times_q[i];
        sel_handle = sel_handle | handles_q[i];
      end
    end
    hit       = |eq_q;
    full      = count_q == CNT_W'(DEPTH);
    do_insert = cmd_i.update && (req_op_q == OP_INSERT) && !hit && !full;
    count_d   = do_insert ? count_q + CNT_W'(1) : count_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_op_q     <= op_e'(op_i);
      req_time_q   <= time_i;
      req_handle_q <= handle_i;
    end
    if (cmd_i.compare) begin
      lt_q <= lt_d;
      eq_q <= eq_d;
      le_q <= le_d;
    end
    if (cmd_i.update && (req_op_q == OP_INSERT)) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (hit) begin
          if (eq_q[k]) handles_q[k] <= req_handle_q;
        end else if (!full) begin
          if (ins_oh[k]) begin
            times_q[k]   <= req_time_q;
            handles_q[k] <= req_handle_q;
          end else if ((k > 0) && !lt_q[(k > 0) ? k - 1 : 0]) begin
            times_q[k]   <= times_q[(k > 0) ? k - 1 : 0];
            handles_q[k] <= handles_q[(k > 0) ? k - 1 : 0];
          end
        end
      end
    end
    if (cmd_i.update) begin
      entry_count_o <= OUT_CNT_W'(count_d);
      if (req_op_q == OP_INSERT) begin
        found_o        <= hit || !full;
        replaced_o     <= hit;
        table_full_o   <= !hit && full;
        entry_time_o   <= req_time_q;
        entry_handle_o <= req_handle_q;
        entry_index_o  <= (!hit && full) ? '0 : OUT_IDX_W'(ins_idx);
      end else begin
        found_o        <= count_q != '0;
        replaced_o     <= 1'b0;
        table_full_o   <= 1'b0;
        entry_time_o   <= (count_q != '0) ? sel_time : '0;
        entry_handle_o <= (count_q != '0) ? sel_handle : '0;
        entry_index_o  <= (count_q != '0) ? OUT_IDX_W'(sel_idx) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/sorted_transition_table.sv =====
// Top level of the sorted transition table.
//
//   channel  dir  tdata                                         tuser
//   s_axis   in   event_time[63:0] descriptor_handle[71:64]     operation[0]
//   m_axis   out  entry_time[63:0] entry_handle[71:64]          found[0] replaced[1]
//                 entry_index[77:72] entry_count[84:78]         table_full[2]
//
// Each item first registers the per-entry compare vectors, then shifts or rewrites
// the entry cells and loads the result register.
// The next item is taken in the update cycle once the result register is free.
// Reset empties the table at once; entry contents are left as they are.
// A stalled result holds the update cycle and the input until it is taken.
module sorted_transition_table
  import srtt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // event_time, descriptor_handle
  input  logic                s_axis_tuser,  // operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,  // entry_time, entry_handle, entry_index, entry_count
  output logic [M_USER_W-1:0] m_axis_tuser   // found, replaced, table_full
);

  srtt_cmd_t              cmd;
  logic                   found, replaced, table_full;
  logic [TIME_W-1:0]      entry_time;
  logic [HANDLE_BITS-1:0] entry_handle;
  logic [OUT_IDX_W-1:0]   entry_index;
  logic [OUT_CNT_W-1:0]   entry_count;

  srtt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  srtt_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (s_axis_tuser),
    .time_i         (s_axis_tdata[TIME_W-1:0]),
    .handle_i       (s_axis_tdata[TIME_W+HANDLE_BITS-1:TIME_W]),
    .found_o        (found),
    .entry_time_o   (entry_time),
    .entry_handle_o (entry_handle),
    .entry_index_o  (entry_index),
    .replaced_o     (replaced),
    .table_full_o   (table_full),
    .entry_count_o  (entry_count)
  );

  assign m_axis_tdata = {3'b000, entry_count, entry_index, entry_handle, entry_time};
  assign m_axis_tuser = {table_full, replaced, found};

endmodule

// ===== rtl/srtt_checker.sv =====
// Port-level checks for the sorted transition table, bound to the top level.
module srtt_checker
  import srtt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata,
  input logic [M_USER_W-1:0] m_axis_tuser
);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[84:78] <= 7'd64))
    else $error("entry_count above table depth");

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (!m_axis_tuser[0] && m_axis_tdata[84:78] == 7'd64))
    else $error("drop reported without a full table");

  a_replace_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[0] && !m_axis_tuser[2]))
    else $error("replace without found");

  a_miss_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[2]) |-> (m_axis_tdata[84:78] == 7'd0))
    else $error("miss on a non-empty table");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind sorted_transition_table srtt_checker u_srtt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb_sorted_transition_table.sv =====
// Self-checking bench for the sorted transition table: directed rows, then random traffic.
`timescale 1ns / 100ps

module tb_sorted_transition_table;
  import srtt_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 630;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [TIME_W-1:0] T_MIN = 64'h8000_0000_0000_0000;
  localparam logic [TIME_W-1:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic                 found;
    logic [TIME_W-1:0]    etime;
    logic [7:0]           ehandle;
    logic [OUT_IDX_W-1:0] eindex;
    logic                 replaced;
    logic                 full;
    logic [OUT_CNT_W-1:0] ecount;
  } tbl_answer_t;

  typedef struct {
    op_e               op;
    logic [TIME_W-1:0] t;
    logic [7:0]        h;
    bit                typed;
    tbl_answer_t       ans;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;   // event_time, descriptor_handle
  logic                s_axis_tuser;   // operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;   // entry_time, entry_handle, entry_index, entry_count
  logic [M_USER_W-1:0] m_axis_tuser;   // found, replaced, table_full

  logic signed [TIME_W-1:0] tbl_times   [DEPTH];
  logic [HANDLE_BITS-1:0]   tbl_handles [DEPTH];
  int unsigned              tbl_count = 0;

  tbl_answer_t pending_answers [$];
  tbl_answer_t next_answer;
  tbl_answer_t want_answer;
  tbl_answer_t row_answer;
  bit          row_typed = 1'b0;
  bit          no_gaps = 1'b0;
  int          mismatch_count = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  stim_row_t   dir_rows [$];

  sorted_transition_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic void add_row(stim_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void queue_answer(tbl_answer_t a);
    pending_answers.insert(pending_answers.size(), a);
  endfunction

  function automatic tbl_answer_t make_answer(logic found, logic [TIME_W-1:0] t, logic [7:0] h,
                                              int idx, logic rep, logic full, int cnt);
    tbl_answer_t a;
    a.found    = found;
    a.etime    = t;
    a.ehandle  = h;
    a.eindex   = OUT_IDX_W'(idx);
    a.replaced = rep;
    a.full     = full;
    a.ecount   = OUT_CNT_W'(cnt);
    return a;
  endfunction

  function automatic tbl_answer_t apply_transition_op(op_e op, logic signed [TIME_W-1:0] t,
                                                      logic [7:0] h);
    int unsigned            i;
    int unsigned            k;
    logic [HANDLE_BITS-1:0] hk;
    hk = h[HANDLE_BITS-1:0];
    i  = 0;
    if (op == OP_INSERT) begin
      while (i < tbl_count && tbl_times[i] < t) i++;
      if (i < tbl_count && tbl_times[i] == t) begin
        tbl_handles[i] = hk;
        return make_answer(1'b1, t, 8'(hk), i, 1'b1, 1'b0, tbl_count);
      end
      if (tbl_count >= DEPTH) return make_answer(1'b0, t, 8'(hk), 0, 1'b0, 1'b1, tbl_count);
      for (k = tbl_count; k > i; k--) begin
        tbl_times[k]   = tbl_times[k-1];
        tbl_handles[k] = tbl_handles[k-1];
      end
      tbl_times[i]   = t;
      tbl_handles[i] = hk;
      tbl_count++;
      return make_answer(1'b1, t, 8'(hk), i, 1'b0, 1'b0, tbl_count);
    end
    if (tbl_count == 0) return make_answer(1'b0, '0, '0, 0, 1'b0, 1'b0, 0);
    while (i < tbl_count && !(t < tbl_times[i])) i++;
    if (i > 0) i--;
    return make_answer(1'b1, tbl_times[i], 8'(tbl_handles[i]), i, 1'b0, 1'b0, tbl_count);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int near_zero;
    near_zero = int'($urandom_range(0, 200)) - 100;
    case ($urandom_range(0, 9))
      0:       return T_MIN;
      1:       return T_MAX;
      2, 3:    return 64'(near_zero);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // call just after a falling edge
  task automatic send_item(op_e op, logic [TIME_W-1:0] t, logic [7:0] h, bit typed,
                           tbl_answer_t a);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    row_typed = typed;
    row_answer = a;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {h, t};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      m_axis_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      next_answer = apply_transition_op(op_e'(s_axis_tuser), s_axis_tdata[63:0],
                                        s_axis_tdata[71:64]);
      queue_answer(row_typed ? row_answer : next_answer);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transfer with nothing expected, tdata %h tuser %h",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want_answer = pending_answers.pop_front();
        check_field("found", TIME_W'(want_answer.found), TIME_W'(m_axis_tuser[0]));
        check_field("replaced", TIME_W'(want_answer.replaced), TIME_W'(m_axis_tuser[1]));
        check_field("table_full", TIME_W'(want_answer.full), TIME_W'(m_axis_tuser[2]));
        check_field("entry_time", want_answer.etime, m_axis_tdata[63:0]);
        check_field("entry_handle", TIME_W'(want_answer.ehandle),
                    TIME_W'(m_axis_tdata[71:64]));
        check_field("entry_index", TIME_W'(want_answer.eindex),
                    TIME_W'(m_axis_tdata[77:72]));
        check_field("entry_count", TIME_W'(want_answer.ecount),
                    TIME_W'(m_axis_tdata[84:78]));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tbl_answer_t    blank;
    op_e            op;
    logic [TIME_W-1:0] t;
    logic [7:0]     h;
    int unsigned    j;
    int             pick;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_INSERT;
    blank = make_answer(1'b0, '0, '0, 0, 1'b0, 1'b0, 0);

    add_row(stim_row_t'{OP_LOOKUP, 64'h123, 8'h77, 1'b1, blank});
    add_row(stim_row_t'{OP_INSERT, 64'h0, 8'h5A, 1'b1,
                        make_answer(1'b1, 64'h0, 8'h5A, 0, 1'b0, 1'b0, 1)});
    add_row(stim_row_t'{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFB, 8'h00, 1'b1,
                        make_answer(1'b1, 64'h0, 8'h5A, 0, 1'b0, 1'b0, 1)});
    add_row(stim_row_t'{OP_INSERT, T_MAX, 8'hFF, 1'b1,
                        make_answer(1'b1, T_MAX, 8'hFF, 1, 1'b0, 1'b0, 2)});
    add_row(stim_row_t'{OP_INSERT, T_MIN, 8'h00, 1'b1,
                        make_answer(1'b1, T_MIN, 8'h00, 0, 1'b0, 1'b0, 3)});
    add_row(stim_row_t'{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h33, 1'b1,
                        make_answer(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'h33, 1, 1'b0, 1'b0, 4)});
    add_row(stim_row_t'{OP_INSERT, 64'h0, 8'hA5, 1'b1,
                        make_answer(1'b1, 64'h0, 8'hA5, 2, 1'b1, 1'b0, 4)});
    add_row(stim_row_t'{OP_LOOKUP, T_MAX, 8'h12, 1'b1,
                        make_answer(1'b1, T_MAX, 8'hFF, 3, 1'b0, 1'b0, 4)});
    add_row(stim_row_t'{OP_LOOKUP, T_MIN, 8'hFF, 1'b1,
                        make_answer(1'b1, T_MIN, 8'h00, 0, 1'b0, 1'b0, 4)});
    add_row(stim_row_t'{OP_LOOKUP, 64'h5, 8'h81, 1'b0, blank});
    add_row(stim_row_t'{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 8'h18, 1'b0, blank});
    add_row(stim_row_t'{OP_INSERT, 64'h5555_5555_5555_5555, 8'hC3, 1'b0, blank});
    add_row(stim_row_t'{OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 8'h3C, 1'b0, blank});
    add_row(stim_row_t'{OP_INSERT, 64'h1, 8'h01, 1'b0, blank});
    add_row(stim_row_t'{OP_LOOKUP, 64'h5555_5555_5555_5556, 8'h00, 1'b0, blank});
    add_row(stim_row_t'{OP_INSERT, T_MIN, 8'hFF, 1'b0, blank});
    add_row(stim_row_t'{OP_INSERT, T_MAX, 8'h00, 1'b0, blank});
    add_row(stim_row_t'{OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFE, 8'hE7, 1'b0, blank});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      @(negedge clk_i);
      send_item(dir_rows[r].op, dir_rows[r].t, dir_rows[r].h, dir_rows[r].typed,
                dir_rows[r].ans);
    end

    // fill the table steadily, then keep pushing replacements, drops and lookups
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      @(negedge clk_i);
      no_gaps = (n >= 250 && n < 350);
      pick = $urandom_range(0, 99);
      h = 8'($urandom_range(0, 255));
      j = $urandom_range(0, tbl_count - 1);
      if (pick < ((tbl_count < DEPTH) ? 22 : 8)) begin
        op = OP_INSERT;
        t  = pick_time();
      end else if (pick < 45) begin
        op = OP_INSERT;
        t  = tbl_times[j];
      end else begin
        op = OP_LOOKUP;
        case ($urandom_range(0, 4))
          0, 1:    t = tbl_times[j];
          2:       t = tbl_times[j] + ($urandom_range(0, 1) ? 64'd1 : 64'hFFFF_FFFF_FFFF_FFFF);
          default: t = pick_time();
        endcase
      end
      send_item(op, t, h, 1'b0, blank);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    no_gaps = 1'b0;
    while (pending_answers.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/srtt_pkg.sv
rtl/srtt_ctrl.sv
rtl/srtt_datapath.sv
rtl/sorted_transition_table.sv
rtl/srtt_checker.sv
test/tb_sorted_transition_table.sv
